>>> src/pffa_pkg.sv
// ----------------------------------------------------------------------------
// pffa_pkg
// Types, codes and microcode program for the page frame free list allocator.
// ----------------------------------------------------------------------------
package pffa_pkg;

    localparam int PAGES  = 128;
    localparam int PAGE_W = 7;
    localparam int LINK_W = 8;
    localparam logic [LINK_W-1:0] PAGE_NONE = LINK_W'(PAGES);

    // request opcodes
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // response status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        page_count;
        logic [PAGE_W-1:0] page_index;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [LINK_W-1:0] head_page;
        logic [LINK_W-1:0] link_page;
        logic              page_is_free;
        logic              page_in_use_count;
    } t_rsp;

    // one page entry in RAM: used mark (ref count, inverse of free mark) and link
    typedef struct packed {
        logic              used;
        logic [LINK_W-1:0] link;
    } t_entry;

    // program steps
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_A_START  = 4'd1;
    localparam logic [3:0] S_A_CHECK  = 4'd2;
    localparam logic [3:0] S_A_SETUP  = 4'd3;
    localparam logic [3:0] S_A_DETACH = 4'd4;
    localparam logic [3:0] S_F_START  = 4'd5;
    localparam logic [3:0] S_F_WALK   = 4'd6;
    localparam logic [3:0] S_Q_START  = 4'd7;
    localparam logic [3:0] S_Q_READ   = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    // datapath actions
    localparam logic [3:0] ACT_NOP      = 4'd0;
    localparam logic [3:0] ACT_LATCH    = 4'd1;
    localparam logic [3:0] ACT_A_START  = 4'd2;
    localparam logic [3:0] ACT_A_CHECK  = 4'd3;
    localparam logic [3:0] ACT_A_SETUP  = 4'd4;
    localparam logic [3:0] ACT_A_DETACH = 4'd5;
    localparam logic [3:0] ACT_F_START  = 4'd6;
    localparam logic [3:0] ACT_F_WALK   = 4'd7;
    localparam logic [3:0] ACT_Q_START  = 4'd8;
    localparam logic [3:0] ACT_Q_READ   = 4'd9;
    localparam logic [3:0] ACT_EMIT     = 4'd10;

    // sequencing
    localparam logic [1:0] COND_ALWAYS   = 2'd0; // go to target
    localparam logic [1:0] COND_LOOP     = 2'd1; // stay / exit to target / fall through
    localparam logic [1:0] COND_DISPATCH = 2'd2; // branch on opcode of accepted request
    localparam logic [1:0] COND_OUT      = 2'd3; // go to target once output slot is free

    typedef struct packed {
        logic [3:0] act;
        logic [1:0] cond;
        logic [3:0] target;
    } t_uword;

    function automatic t_uword ucode_rom(input logic [3:0] pc);
        t_uword w;
        case (pc)
            S_IDLE:     w = '{ACT_LATCH,    COND_DISPATCH, S_IDLE};
            S_A_START:  w = '{ACT_A_START,  COND_LOOP,     S_EMIT};
            S_A_CHECK:  w = '{ACT_A_CHECK,  COND_LOOP,     S_EMIT};
            S_A_SETUP:  w = '{ACT_A_SETUP,  COND_ALWAYS,   S_A_DETACH};
            S_A_DETACH: w = '{ACT_A_DETACH, COND_LOOP,     S_EMIT};
            S_F_START:  w = '{ACT_F_START,  COND_ALWAYS,   S_F_WALK};
            S_F_WALK:   w = '{ACT_F_WALK,   COND_LOOP,     S_EMIT};
            S_Q_START:  w = '{ACT_Q_START,  COND_ALWAYS,   S_Q_READ};
            S_Q_READ:   w = '{ACT_Q_READ,   COND_ALWAYS,   S_EMIT};
            S_EMIT:     w = '{ACT_EMIT,     COND_OUT,      S_IDLE};
            default:    w = '{ACT_NOP,      COND_ALWAYS,   S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [3:0] dispatch(input logic [1:0] opcode);
        logic [3:0] t;
        case (opcode)
            OP_ALLOC: t = S_A_START;
            OP_FREE:  t = S_F_START;
            OP_QUERY: t = S_Q_START;
            default:  t = S_EMIT;
        endcase
        return t;
    endfunction

endpackage

>>> src/pffa_ram.sv
// ----------------------------------------------------------------------------
// pffa_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pffa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/page_frame_free_list_allocator.sv
// ----------------------------------------------------------------------------
// page_frame_free_list_allocator
// Free list page frame allocator driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req): allocate a count of
//   pages, free a chain starting at a page, or query one page. Response
//   channel (o_rsp_valid / i_rsp_ready / o_rsp): exactly one response per
//   request, in order.
//   One request is processed at a time; o_req_ready is high only while the
//   sequencer sits at its idle step. The link/mark RAM has one read port, so
//   the list walks take one page per cycle. An allocate runs a check walk,
//   then a detach walk; a short list ends the check walk early, and a zero
//   count or an empty list skips both walks. A free walks the chain, at
//   most PAGES pages; a query reads one page; any other opcode goes
//   straight to the response step. The longest request is an allocate of
//   count 255 on a free list that a double free has closed into a loop.
//   The response sits in an output register and the next request is
//   taken while it waits; if the receiver stalls, the sequencer holds at
//   its last step.
//   Reset clears the per-page valid bits, so every page reads back free and
//   linked to the next index, and the list head returns to page 0; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module page_frame_free_list_allocator
    import pffa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    localparam t_rsp RSP_IDLE = '{ST_OK, PAGE_NONE, PAGE_NONE, 1'b0, 1'b0};

    // sequencer
    logic [3:0]        r_pc, n_pc;
    t_uword            uw;
    logic              f_stay, f_exit;

    // datapath
    t_req              r_req, n_req;
    t_rsp              r_res, n_res;
    t_rsp              r_out, n_out;
    logic              r_out_valid, n_out_valid;
    logic [PAGE_W-1:0] r_cur, n_cur;
    logic [7:0]        r_cnt, n_cnt;
    logic [PAGE_W-1:0] r_walk, n_walk;
    logic [LINK_W-1:0] r_head, n_head;

    // RAM and read path
    logic              ram_we;
    logic [PAGE_W-1:0] ram_waddr, ram_raddr;
    t_entry            ram_wdata, ram_q;
    logic [PAGES-1:0]  r_vld;
    logic              r_rd_vld;
    logic [PAGE_W-1:0] r_rd_addr;
    logic              r_byp;
    t_entry            r_byp_data;
    t_entry            rd_word;
    logic [LINK_W-1:0] rd_link;
    logic              link_none;
    logic              req_acc, out_free;

    pffa_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (PAGES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign uw          = ucode_rom(r_pc);
    assign o_req_ready = (r_pc == S_IDLE);
    assign req_acc     = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_out;

    // entries never written read as their reset value
    always_comb begin
        if (r_byp) begin
            rd_word = r_byp_data;
        end else if (r_rd_vld) begin
            rd_word = ram_q;
        end else if (r_rd_addr == PAGE_W'(PAGES - 1)) begin
            rd_word = '{1'b0, PAGE_NONE};
        end else begin
            rd_word = '{1'b0, LINK_W'(r_rd_addr) + LINK_W'(1)};
        end
    end

    assign rd_link   = rd_word.link;
    assign link_none = (rd_link >= PAGE_NONE);

    // datapath actions
    always_comb begin
        n_req       = r_req;
        n_res       = r_res;
        n_out       = r_out;
        n_cur       = r_cur;
        n_cnt       = r_cnt;
        n_walk      = r_walk;
        n_head      = r_head;
        f_stay      = 1'b0;
        f_exit      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_cur;
        ram_wdata   = '{1'b0, PAGE_NONE};
        ram_raddr   = r_cur;
        n_out_valid = r_out_valid && !i_rsp_ready;

        case (uw.act)
            ACT_LATCH: begin
                if (req_acc) begin
                    n_req = i_req;
                    n_res = RSP_IDLE;
                end
            end
            ACT_A_START: begin
                if (r_req.page_count == 8'd0) begin
                    n_res.status = ST_ZERO;
                    f_exit       = 1'b1;
                end else if (r_head >= PAGE_NONE) begin
                    n_res.status = ST_NOSPACE;
                    f_exit       = 1'b1;
                end else begin
                    n_cur     = r_head[PAGE_W-1:0];
                    n_cnt     = r_req.page_count;
                    ram_raddr = r_head[PAGE_W-1:0];
                end
            end
            ACT_A_CHECK: begin
                // r_cur is a page; count it and look at its link
                if (r_cnt == 8'd1) begin
                    f_exit = 1'b0;
                end else if (link_none) begin
                    n_res.status = ST_NOSPACE;
                    f_exit       = 1'b1;
                end else begin
                    n_cur     = rd_link[PAGE_W-1:0];
                    n_cnt     = r_cnt - 8'd1;
                    ram_raddr = rd_link[PAGE_W-1:0];
                    f_stay    = 1'b1;
                end
            end
            ACT_A_SETUP: begin
                n_cur           = r_head[PAGE_W-1:0];
                n_cnt           = r_req.page_count;
                ram_raddr       = r_head[PAGE_W-1:0];
                n_res.head_page = r_head;
            end
            ACT_A_DETACH: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                if (r_cnt == 8'd1) begin
                    // last page terminates the allocated chain
                    ram_wdata = '{1'b1, PAGE_NONE};
                    n_head    = link_none ? PAGE_NONE : rd_link;
                    f_exit    = 1'b1;
                end else begin
                    ram_wdata = '{1'b1, rd_link};
                    n_cur     = rd_link[PAGE_W-1:0];
                    n_cnt     = r_cnt - 8'd1;
                    ram_raddr = rd_link[PAGE_W-1:0];
                    f_stay    = 1'b1;
                end
            end
            ACT_F_START: begin
                n_cur     = r_req.page_index;
                n_walk    = '0;
                ram_raddr = r_req.page_index;
            end
            ACT_F_WALK: begin
                ram_we    = 1'b1;
                ram_waddr = r_cur;
                ram_wdata = '{1'b0, r_head};
                n_head    = LINK_W'(r_cur);
                n_walk    = r_walk + PAGE_W'(1);
                // walk is bounded so a cycle left by a double free terminates
                if (link_none || r_walk == PAGE_W'(PAGES - 1)) begin
                    f_exit = 1'b1;
                end else begin
                    n_cur     = rd_link[PAGE_W-1:0];
                    ram_raddr = rd_link[PAGE_W-1:0];
                    f_stay    = 1'b1;
                end
            end
            ACT_Q_START: begin
                ram_raddr = r_req.page_index;
            end
            ACT_Q_READ: begin
                n_res.link_page         = link_none ? PAGE_NONE : rd_link;
                n_res.page_is_free      = !rd_word.used;
                n_res.page_in_use_count = rd_word.used;
            end
            ACT_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                f_exit = 1'b0;
            end
        endcase
    end

    // step counter
    always_comb begin
        n_pc = r_pc;
        case (uw.cond)
            COND_ALWAYS: n_pc = uw.target;
            COND_LOOP: begin
                if (f_exit) begin
                    n_pc = uw.target;
                end else if (f_stay) begin
                    n_pc = r_pc;
                end else begin
                    n_pc = r_pc + 4'd1;
                end
            end
            COND_DISPATCH: begin
                if (req_acc) begin
                    n_pc = dispatch(i_req.opcode);
                end
            end
            COND_OUT: begin
                if (out_free) begin
                    n_pc = uw.target;
                end
            end
            default: n_pc = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= S_IDLE;
            r_out_valid <= 1'b0;
            r_head      <= '0;
            r_vld       <= '0;
        end else begin
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            r_head      <= n_head;
            if (ram_we) begin
                r_vld[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_res      <= n_res;
        r_out      <= n_out;
        r_cur      <= n_cur;
        r_cnt      <= n_cnt;
        r_walk     <= n_walk;
        r_rd_addr  <= ram_raddr;
        r_rd_vld   <= r_vld[ram_raddr];
        // read of the entry being written returns the new data
        r_byp      <= ram_we && (ram_waddr == ram_raddr);
        r_byp_data <= ram_wdata;
    end

    // ------------------------------------------------------------------------
    a_acc_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> r_pc != S_IDLE)
        else $error("request accepted but sequencer stayed idle");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_IDLE || r_pc == S_EMIT) |-> !ram_we)
        else $error("RAM written outside a walk");

    a_rsp_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid || i_rsp_ready) && r_pc != S_EMIT |=> !r_out_valid)
        else $error("response loaded outside the emit step");

    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == S_EMIT && r_req.opcode == OP_ALLOC && r_res.status == ST_OK)
        |-> r_res.head_page != PAGE_NONE)
        else $error("successful allocate without a chain head");

endmodule
